>>> design/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MEDB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MEDB_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MEDB_ASSERT(lbl, prop, msg)
`define MEDB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> design/medb_pkg.sv
package medb_pkg;

	// control broadcast from the top level to every cell of both chains
	typedef struct packed {
		logic ins;
		logic clr;
	} medb_ctrl_t;

endpackage

>>> design/medb_in_if.sv
interface medb_in_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] left_sample;
	logic [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

>>> design/medb_out_if.sv
interface medb_out_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] left_median;
	logic [SAMPLE_BITS-1:0] right_median;

	modport source (output valid, output left_median, output right_median, input ready);
	modport sink (input valid, input left_median, input right_median, output ready);
endinterface

>>> design/medb_cell.sv
module medb_cell
	import medb_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  medb_ctrl_t             ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   prev_valid,
	input  logic                   prev_gt,
	input  logic [SAMPLE_BITS-1:0] prev_value,
	output logic                   valid,
	output logic                   gt,
	output logic [SAMPLE_BITS-1:0] value,
	output logic [SAMPLE_BITS-1:0] next_value
);
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] value_q;

	// an empty cell counts as larger than any sample
	assign gt = !valid_q || (value_q > sample);

	// cells above the insertion point take their lower neighbor's value
	always_comb begin
		if (gt) begin
			next_value = prev_gt ? prev_value : sample;
		end else begin
			next_value = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			value_q <= next_value;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
endmodule

>>> design/medb_chain.sv
module medb_chain
	import medb_pkg::*;
#(
	parameter int SAMPLE_COUNT = 19,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  medb_ctrl_t             ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] median_next
);
	localparam int MID = SAMPLE_COUNT / 2;

	logic                   valid [SAMPLE_COUNT];
	logic                   gt    [SAMPLE_COUNT];
	logic [SAMPLE_BITS-1:0] value [SAMPLE_COUNT];
	logic [SAMPLE_BITS-1:0] nxt   [SAMPLE_COUNT];

	// cells kept in ascending order, cell 0 smallest
	for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			medb_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (sample),
				.prev_valid (1'b1),
				.prev_gt    (1'b0),
				.prev_value (sample),
				.valid      (valid[i]),
				.gt         (gt[i]),
				.value      (value[i]),
				.next_value (nxt[i])
			);
		end else begin : g_body
			medb_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (sample),
				.prev_valid (valid[i-1]),
				.prev_gt    (gt[i-1]),
				.prev_value (value[i-1]),
				.valid      (valid[i]),
				.gt         (gt[i]),
				.value      (value[i]),
				.next_value (nxt[i])
			);
		end
	end

	assign median_next = nxt[MID];
endmodule

>>> design/dual_channel_block_median.sv
// Block median of two sample channels. Each accepted item carries a left and
// a right sample; every SAMPLE_COUNT items form a block, and the item that
// closes a block yields one result, the value at position SAMPLE_COUNT/2 of
// each channel's samples in ascending order (the median for odd counts).
// Other items yield nothing. One item is taken per clock: each channel is a
// row of SAMPLE_COUNT compare-and-shift cells that inserts the new sample in
// sorted place in the same cycle. The result appears in the output register
// in the cycle after the closing item; while it waits, earlier items of the
// next block are still taken and only the next closing item stalls.
`include "assert_macros.svh"

module dual_channel_block_median
	import medb_pkg::*;
#(
	parameter int SAMPLE_COUNT = 19,
	parameter int SAMPLE_BITS  = 10
) (
	input logic             clk,
	input logic             arst_n,
	medb_in_if.sink         samples,
	medb_out_if.source      medians
);
	localparam int CW = $clog2(SAMPLE_COUNT + 1);

	logic [CW-1:0]          fill_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] left_q;
	logic [SAMPLE_BITS-1:0] right_q;
	logic                   last;
	logic                   acc;
	medb_ctrl_t             ctrl;
	logic [SAMPLE_BITS-1:0] left_next;
	logic [SAMPLE_BITS-1:0] right_next;

	assign last          = (fill_q == CW'(SAMPLE_COUNT - 1));
	assign samples.ready = !(last && out_valid_q && !medians.ready);
	assign acc           = samples.valid && samples.ready;
	assign ctrl.ins      = acc;
	assign ctrl.clr      = acc && last;

	medb_chain #(.SAMPLE_COUNT(SAMPLE_COUNT), .SAMPLE_BITS(SAMPLE_BITS)) u_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (samples.left_sample),
		.median_next (left_next)
	);

	medb_chain #(.SAMPLE_COUNT(SAMPLE_COUNT), .SAMPLE_BITS(SAMPLE_BITS)) u_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (samples.right_sample),
		.median_next (right_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				fill_q <= last ? '0 : fill_q + CW'(1);
			end
			if (ctrl.clr) begin
				out_valid_q <= 1'b1;
			end else if (medians.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// median taken from the chain's insert path as the block closes
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			left_q  <= left_next;
			right_q <= right_next;
		end
	end

	assign medians.valid        = out_valid_q;
	assign medians.left_median  = left_q;
	assign medians.right_median = right_q;

	`MEDB_ASSERT_NEVER(a_fill_range, fill_q > CW'(SAMPLE_COUNT - 1), "fill count out of range")
	`MEDB_ASSERT(a_block_restart, ctrl.clr |=> fill_q == '0, "block did not restart")
	`MEDB_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(ctrl.clr), "result without block end")
	`MEDB_ASSERT(a_no_overwrite, (out_valid_q && !medians.ready) |-> !ctrl.clr, "pending result overwritten")
endmodule
